// File: design/gap_search_block_allocator_macros.svh
// Assertion macros shared by the allocator checker.
`ifndef GAP_SEARCH_BLOCK_ALLOCATOR_MACROS_SVH
`define GAP_SEARCH_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GSBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, disabled during reset.
`define GSBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// File: design/gsba_pkg.sv
// ----------------------------------------------------------------------------
// Allocator package
// Shared constants, status codes and cell control type.
// ----------------------------------------------------------------------------
package gsba_pkg;

  localparam int DefMemBytes  = 4096;
  localparam int DefMaxBlocks = 16;
  localparam int HdrBytes     = 8;
  localparam int ReqW         = 16;
  localparam int StatusW      = 2;
  localparam int PayloadW     = 12;
  localparam int InDataW      = 16;
  localparam int OutDataW     = 16;

  localparam logic [StatusW-1:0] StGrant = 2'd0;
  localparam logic [StatusW-1:0] StZero  = 2'd1;
  localparam logic [StatusW-1:0] StNoFit = 2'd2;
  localparam logic [StatusW-1:0] StFull  = 2'd3;

  typedef struct packed {
    logic shift;
    logic load;
  } gsba_cell_ctl_t;

endpackage

// File: design/gap_search_block_allocator.sv
// ----------------------------------------------------------------------------
// Gap search block allocator
// First-fit allocator over a ring of entry cells.
// ----------------------------------------------------------------------------
// Each input word on the s_axis channel is a payload byte count. The block
// answers each request with exactly one output word on m_axis carrying a
// status and the payload offset (header offset plus 8) when granted.
// The table is a ring of MAX_BLOCKS cells that rotates by one cell per cycle
// while aligning or scanning; the cell at the head is examined each cycle of the scan.
// A zero request or a full table goes straight to the result. Otherwise the
// first tried entry is rotated to the head, and each tried entry then takes
// a full turn of the ring for the neighbor search, is evaluated, and the
// next one is aligned. Writing a granted entry rotates the ring until the
// slot after the last entry reaches the head.
// One request is handled at a time; s_axis_tready_o is high only when idle.
// Reset empties the table and drops any pending result. When the receiver
// stalls, the result is held in the output register and the next request
// may still be accepted; its result waits until the output is free.
// ----------------------------------------------------------------------------
module gap_search_block_allocator #(
  parameter int MEM_BYTES  = gsba_pkg::DefMemBytes,
  parameter int MAX_BLOCKS = gsba_pkg::DefMaxBlocks
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [15:0] request_bytes
  input  logic [gsba_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [1:0] status, [13:2] payload_offset, [15:14] zero
  output logic [gsba_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import gsba_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam int SW = AW + 1;
  localparam int CW = (AW + 2 > 18) ? AW + 2 : 18;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int NW = $clog2(MAX_BLOCKS + 1);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SAlign  = 3'd1;
  localparam logic [2:0] SScan   = 3'd2;
  localparam logic [2:0] SEval   = 3'd3;
  localparam logic [2:0] SWalign = 3'd4;
  localparam logic [2:0] SResult = 3'd5;

  localparam logic [CW-1:0] MemC  = CW'(MEM_BYTES);
  localparam logic [CW-1:0] HdrC  = CW'(HdrBytes);
  localparam logic [IW-1:0] LastI = IW'(MAX_BLOCKS - 1);

  logic [2:0]         state_q, state_d;
  logic [NW-1:0]      count_q, count_d;
  logic [IW-1:0]      head_q, head_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [IW-1:0]      sc_q, sc_d;
  logic [CW-1:0]      need_q, need_d;
  logic [CW-1:0]      pos_q, pos_d;
  logic [CW-1:0]      end_q, end_d;
  logic [CW-1:0]      right_q, right_d;
  logic [CW-1:0]      left_q, left_d;
  logic [AW-1:0]      where_q, where_d;
  logic [StatusW-1:0] stat_q, stat_d;
  logic               mvalid_q, mvalid_d;
  logic [OutDataW-1:0] mdata_q, mdata_d;

  logic shift, wr;
  logic [AW-1:0] cell_off  [MAX_BLOCKS];
  logic [SW-1:0] cell_size [MAX_BLOCKS];
  logic [CW-1:0] head_off, head_end;
  logic          head_valid;
  logic [16:0]   rnd;
  logic [CW-1:0] out_off;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    gsba_cell_ctl_t ctl;
    assign ctl.shift = shift;
    assign ctl.load  = wr && (k == 0);
    gsba_cell #(.AW(AW), .SW(SW)) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .load_off_i  (where_q),
      .load_size_i (SW'(need_q - HdrC)),
      .nb_off_i    (cell_off[(k + 1) % MAX_BLOCKS]),
      .nb_size_i   (cell_size[(k + 1) % MAX_BLOCKS]),
      .off_o       (cell_off[k]),
      .size_o      (cell_size[k])
    );
  end

  assign head_off   = CW'(cell_off[0]);
  assign head_end   = head_off + HdrC + CW'(cell_size[0]);
  assign head_valid = NW'(head_q) < count_q;
  assign rnd        = ({1'b0, s_axis_tdata_i[ReqW-1:0]} + 17'd3) & ~17'd3;
  assign out_off    = CW'(where_q) + HdrC;
  assign s_axis_tready_o = (state_q == SIdle);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    head_d   = head_q;
    idx_d    = idx_q;
    sc_d     = sc_q;
    need_d   = need_q;
    pos_d    = pos_q;
    end_d    = end_q;
    right_d  = right_q;
    left_d   = left_q;
    where_d  = where_q;
    stat_d   = stat_q;
    mvalid_d = mvalid_q && !m_axis_tready_i;
    mdata_d  = mdata_q;
    shift    = 1'b0;
    wr       = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (s_axis_tvalid_i) begin
          need_d  = CW'(rnd) + HdrC;
          state_d = SResult;
          if (s_axis_tdata_i[ReqW-1:0] == '0) begin
            stat_d = StZero;
          end else if (count_q >= NW'(MAX_BLOCKS)) begin
            stat_d = StFull;
          end else if (count_q == '0) begin
            if (CW'(rnd) + HdrC <= MemC) begin
              where_d = '0;
              state_d = SWalign;
            end else begin
              stat_d = StNoFit;
            end
          end else begin
            idx_d   = '0;
            left_d  = MemC;
            state_d = SAlign;
          end
        end
      end
      SAlign: begin
        if (head_q == idx_q) begin
          pos_d   = head_off;
          end_d   = head_end;
          right_d = MemC;
          sc_d    = '0;
          state_d = SScan;
        end else begin
          shift = 1'b1;
        end
      end
      SScan: begin
        shift = 1'b1;
        if (head_valid) begin
          if (head_off > pos_q && head_off < right_q) right_d = head_off;
          if (head_off < left_q) left_d = head_off;
        end
        sc_d = sc_q + 1'b1;
        if (sc_q == LastI) state_d = SEval;
      end
      SEval: begin
        if (end_q <= right_q && right_q - end_q >= need_q) begin
          where_d = AW'(end_q);
          state_d = SWalign;
        end else if (NW'(idx_q) == count_q - 1'b1) begin
          if (left_q >= need_q) begin
            where_d = '0;
            state_d = SWalign;
          end else begin
            stat_d  = StNoFit;
            state_d = SResult;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = SAlign;
        end
      end
      SWalign: begin
        if (head_q == count_q[IW-1:0]) begin
          wr      = 1'b1;
          count_d = count_q + 1'b1;
          stat_d  = StGrant;
          state_d = SResult;
        end else begin
          shift = 1'b1;
        end
      end
      SResult: begin
        if (!mvalid_q || m_axis_tready_i) begin
          mvalid_d = 1'b1;
          mdata_d  = '0;
          mdata_d[StatusW-1:0] = stat_q;
          if (stat_q == StGrant) begin
            mdata_d[StatusW +: PayloadW] = out_off[PayloadW-1:0];
          end
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
    if (shift) head_d = (head_q == LastI) ? '0 : head_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      count_q  <= '0;
      head_q   <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      head_q   <= head_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    sc_q    <= sc_d;
    need_q  <= need_d;
    pos_q   <= pos_d;
    end_q   <= end_d;
    right_q <= right_d;
    left_q  <= left_d;
    where_q <= where_d;
    stat_q  <= stat_d;
    mdata_q <= mdata_d;
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = mdata_q;

endmodule

// File: design/gsba_cell.sv
// ----------------------------------------------------------------------------
// Allocator table cell
// Holds one block entry; loads a new entry or takes its neighbor's entry.
// ----------------------------------------------------------------------------
module gsba_cell #(
  parameter int AW = 12,
  parameter int SW = 13
) (
  input  logic                    clk_i,
  input  gsba_pkg::gsba_cell_ctl_t ctl_i,
  input  logic [AW-1:0]           load_off_i,
  input  logic [SW-1:0]           load_size_i,
  input  logic [AW-1:0]           nb_off_i,
  input  logic [SW-1:0]           nb_size_i,
  output logic [AW-1:0]           off_o,
  output logic [SW-1:0]           size_o
);

  logic [AW-1:0] off_q;
  logic [SW-1:0] size_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      off_q  <= load_off_i;
      size_q <= load_size_i;
    end else if (ctl_i.shift) begin
      off_q  <= nb_off_i;
      size_q <= nb_size_i;
    end
  end

  assign off_o  = off_q;
  assign size_o = size_q;

endmodule

// File: design/gsba_checker.sv
// ----------------------------------------------------------------------------
// Allocator port checker
// Checks port behavior of the allocator over time.
// ----------------------------------------------------------------------------
`include "gap_search_block_allocator_macros.svh"

module gsba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [gsba_pkg::InDataW-1:0]  s_axis_tdata_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [gsba_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import gsba_pkg::*;

  `GSBA_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)
  `GSBA_ASSERT_NEXT(a_data_hold, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o))
  `GSBA_ASSERT_NOW(a_fail_zero, m_axis_tvalid_o && m_axis_tdata_o[1:0] != StGrant, m_axis_tdata_o[15:2] == '0)
  `GSBA_ASSERT_NEXT(a_one_at_time, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

endmodule

bind gap_search_block_allocator gsba_checker u_gsba_checker (.*);
